>>> rtl/heightmap_normal_engine_core_macros.svh
// Assertion macros used by the heightmap normal engine core.
`ifndef HEIGHTMAP_NORMAL_ENGINE_CORE_MACROS_SVH
`define HEIGHTMAP_NORMAL_ENGINE_CORE_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define HNE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define HNE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hne_pkg.sv
// Constants of the heightmap normal engine.
`default_nettype none
package hne_pkg;
    localparam int CFG_W     = 8;
    localparam int COORD_W   = 7;
    localparam int IN_H_W    = 16;
    localparam int OUT_XZ_W  = 16;
    localparam int OUT_Y_W   = 15;
    localparam int IDX_W     = 16;
    localparam int NORM_W    = 20;
    localparam int SQ_W      = 2 * NORM_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = 64;
    localparam int ROOT_STEPS = 32;
    localparam int QUO_BITS  = 16;
    localparam int FRAC_SHIFT = 24;
    localparam int SQ_SHIFT  = 20;
    localparam int EXT_W     = 33;
    localparam int LEN_W     = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;
    localparam logic [CFG_W-1:0] CFG_MIN   = 8'd3;
    localparam logic [EXT_W-1:0] Y_BASE    = 33'd512;
    localparam logic [QUO_BITS-1:0] UNIT_Q = 16'd16384;

    localparam logic CFG_IDX_WIDTH = 1'b0;
    localparam logic CFG_IDX_DEPTH = 1'b1;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
endpackage
`default_nettype wire

>>> rtl/heightmap_normal_engine_core.sv
// Heightmap store with a pipelined central-difference normal unit.
// Stages: input, address, read, diff, shift, square, sum, root, divide, output.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// The four neighbor reads use four height copies. Write items produce no result.
// Reset is synchronous, active low; it clears valid bits and sets both sizes to 128.
// The height store is not cleared; heights are undefined until written.
`default_nettype none
`include "heightmap_normal_engine_core_macros.svh"
module heightmap_normal_engine_core #(
    parameter int MAX_WIDTH   = 128,
    parameter int MAX_DEPTH   = 128,
    parameter int HEIGHT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [6:0] cell_x, [13:7] cell_z, [29:14] height_value, [31:30] zero
    input  wire logic [31:0] s_axis_tdata,
    // [0] operation
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] normal_x, [30:16] normal_y, [46:31] normal_z, [47] zero
    output logic [47:0]      m_axis_tdata
);
    localparam int STORE_SIZE = MAX_WIDTH * MAX_DEPTH;
    localparam int ADDR_W = $clog2(STORE_SIZE);
    localparam int HB = HEIGHT_BITS;
    localparam logic [7:0] W_LIMIT = 8'((MAX_WIDTH > 255) ? 255 : MAX_WIDTH);
    localparam logic [7:0] D_LIMIT = 8'((MAX_DEPTH > 255) ? 255 : MAX_DEPTH);
    localparam int NQ = hne_pkg::QUO_BITS;
    localparam int NR = hne_pkg::ROOT_STEPS;
    localparam int RW = hne_pkg::ROOT_W;

    function automatic logic [7:0] clamp_cfg(input logic [7:0] v, input logic [7:0] lim);
        if (v < hne_pkg::CFG_MIN) begin
            return hne_pkg::CFG_MIN;
        end else if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

    logic w_adv;
    logic [7:0] r_grid_width, r_grid_depth;

    // input stage
    logic r_a_vld, r_a_op;
    logic [6:0] r_a_x, r_a_z;
    logic [HB-1:0] r_a_h;
    logic [31:0] n_h32;

    // address stage
    logic [7:0] n_qx1, n_qx, n_qz1, n_qz, n_wx, n_wz;
    logic n_wr_ok;
    logic r_b_vld, r_b_op, r_b_wr_ok;
    logic [HB-1:0] r_b_h;
    logic [ADDR_W-1:0] r_b_addr [4];
    logic [ADDR_W-1:0] r_b_waddr;
    logic [ADDR_W-1:0] n_addr [4];
    logic [ADDR_W-1:0] n_waddr;

    // memory read stage
    logic r_c_vld;
    logic [HB-1:0] r_c_rd [4];

    // difference stage
    logic signed [HB:0] n_dx, n_dz;
    logic [HB:0] n_adx, n_adz;
    logic r_d_vld, r_d_neg_x, r_d_neg_z;
    logic [HB-1:0] r_d_ax, r_d_az;

    // range shift stage
    logic [hne_pkg::EXT_W-1:0] n_top;
    logic [hne_pkg::LEN_W-1:0] n_len, n_sh;
    logic r_e_vld, r_e_neg_x, r_e_neg_z;
    logic [hne_pkg::NORM_W-1:0] r_e_ax, r_e_ay, r_e_az;

    // square stage
    logic r_f_vld, r_f_neg_x, r_f_neg_z;
    logic [hne_pkg::NORM_W-1:0] r_f_ax, r_f_ay, r_f_az;
    logic [hne_pkg::SQ_W-1:0] r_f_sx, r_f_sy, r_f_sz;

    // sum stage
    logic r_g_vld, r_g_neg_x, r_g_neg_z;
    logic [hne_pkg::NORM_W-1:0] r_g_ax, r_g_ay, r_g_az;
    logic [hne_pkg::SUM_W-1:0] r_g_s;

    // square root stages
    logic          r_rt_vld  [NR+1];
    logic          r_rt_negx [NR+1];
    logic          r_rt_negz [NR+1];
    logic [RW-1:0] r_rt_v    [NR+1];
    logic [RW-1:0] r_rt_r    [NR+1];
    logic [hne_pkg::NORM_W-1:0] r_rt_ax [NR+1];
    logic [hne_pkg::NORM_W-1:0] r_rt_ay [NR+1];
    logic [hne_pkg::NORM_W-1:0] r_rt_az [NR+1];

    // divider stages, lanes x, y, z
    logic [RW-1:0] n_root;
    logic          r_dv_vld  [NQ+1];
    logic          r_dv_negx [NQ+1];
    logic          r_dv_negz [NQ+1];
    logic [RW-1:0] r_dv_r    [NQ+1];
    logic [RW-1:0] r_dv_rem  [NQ+1][3];
    logic [NQ-1:0] r_dv_q    [NQ+1][3];

    // output stage
    logic [NQ-1:0] n_mag [3];
    logic r_out_vld;
    logic [hne_pkg::OUT_XZ_W-1:0] r_out_nx, r_out_nz;
    logic [hne_pkg::OUT_Y_W-1:0]  r_out_ny;

    assign w_adv = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= clamp_cfg(hne_pkg::CFG_RESET, W_LIMIT);
            r_grid_depth <= clamp_cfg(hne_pkg::CFG_RESET, D_LIMIT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hne_pkg::CFG_IDX_WIDTH: r_grid_width <= clamp_cfg(i_cfg_data, W_LIMIT);
                hne_pkg::CFG_IDX_DEPTH: r_grid_depth <= clamp_cfg(i_cfg_data, D_LIMIT);
                default: ;
            endcase
        end
    end

    // input stage
    assign n_h32 = 32'(signed'(s_axis_tdata[29:14]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_op <= s_axis_tuser;
            r_a_x  <= s_axis_tdata[6:0];
            r_a_z  <= s_axis_tdata[13:7];
            r_a_h  <= n_h32[HB-1:0];
        end
    end

    // address stage
    always_comb begin
        n_wx  = {1'b0, r_a_x};
        n_wz  = {1'b0, r_a_z};
        n_qx1 = (r_a_x == 7'd0) ? 8'd1 : n_wx;
        n_qx  = (n_qx1 > (r_grid_width - 8'd2)) ? (r_grid_width - 8'd2) : n_qx1;
        n_qz1 = (r_a_z == 7'd0) ? 8'd1 : n_wz;
        n_qz  = (n_qz1 > (r_grid_depth - 8'd2)) ? (r_grid_depth - 8'd2) : n_qz1;
        n_wr_ok = (n_wx < r_grid_width) && (n_wz < r_grid_depth);
        n_addr[0] = ADDR_W'(16'(n_qx - 8'd1) * 16'(r_grid_depth) + 16'(n_qz));
        n_addr[1] = ADDR_W'(16'(n_qx + 8'd1) * 16'(r_grid_depth) + 16'(n_qz));
        n_addr[2] = ADDR_W'(16'(n_qx) * 16'(r_grid_depth) + 16'(n_qz) + 16'd1);
        n_addr[3] = ADDR_W'(16'(n_qx) * 16'(r_grid_depth) + 16'(n_qz) - 16'd1);
        n_waddr   = ADDR_W'(16'(n_wx) * 16'(r_grid_depth) + 16'(n_wz));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_op    <= r_a_op;
            r_b_wr_ok <= n_wr_ok;
            r_b_h     <= r_a_h;
            r_b_addr  <= n_addr;
            r_b_waddr <= n_waddr;
        end
    end

    // four height copies: left, right, up, down
    for (genvar k = 0; k < 4; k++) begin : g_copy
        logic [HB-1:0] mem [STORE_SIZE];
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_b_vld && (r_b_op == hne_pkg::OP_WRITE) && r_b_wr_ok) begin
                    mem[r_b_waddr] <= r_b_h;
                end
                r_c_rd[k] <= mem[r_b_addr[k]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_c_vld <= r_b_vld && (r_b_op == hne_pkg::OP_QUERY);
        end
    end

    // difference stage
    always_comb begin
        n_dx  = $signed({r_c_rd[0][HB-1], r_c_rd[0]}) - $signed({r_c_rd[1][HB-1], r_c_rd[1]});
        n_dz  = $signed({r_c_rd[2][HB-1], r_c_rd[2]}) - $signed({r_c_rd[3][HB-1], r_c_rd[3]});
        n_adx = n_dx[HB] ? (HB+1)'(-n_dx) : n_dx;
        n_adz = n_dz[HB] ? (HB+1)'(-n_dz) : n_dz;
    end

    // range shift, squares and sum stages
    always_comb begin
        n_top = hne_pkg::EXT_W'(r_d_ax) | hne_pkg::EXT_W'(r_d_az) | hne_pkg::Y_BASE;
        n_len = '0;
        for (int i = 0; i < hne_pkg::EXT_W; i++) begin
            if (n_top[i]) begin
                n_len = hne_pkg::LEN_W'(i + 1);
            end
        end
        n_sh = (n_len > hne_pkg::LEN_W'(hne_pkg::NORM_W))
             ? (n_len - hne_pkg::LEN_W'(hne_pkg::NORM_W)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (w_adv) begin
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_neg_x <= n_dx[HB];
            r_d_neg_z <= n_dz[HB];
            r_d_ax    <= n_adx[HB-1:0];
            r_d_az    <= n_adz[HB-1:0];

            r_e_neg_x <= r_d_neg_x;
            r_e_neg_z <= r_d_neg_z;
            r_e_ax <= hne_pkg::NORM_W'(hne_pkg::EXT_W'(r_d_ax) >> n_sh);
            r_e_ay <= hne_pkg::NORM_W'(hne_pkg::Y_BASE >> n_sh);
            r_e_az <= hne_pkg::NORM_W'(hne_pkg::EXT_W'(r_d_az) >> n_sh);

            r_f_neg_x <= r_e_neg_x;
            r_f_neg_z <= r_e_neg_z;
            r_f_ax <= r_e_ax;
            r_f_ay <= r_e_ay;
            r_f_az <= r_e_az;
            r_f_sx <= hne_pkg::SQ_W'(r_e_ax) * hne_pkg::SQ_W'(r_e_ax);
            r_f_sy <= hne_pkg::SQ_W'(r_e_ay) * hne_pkg::SQ_W'(r_e_ay);
            r_f_sz <= hne_pkg::SQ_W'(r_e_az) * hne_pkg::SQ_W'(r_e_az);

            r_g_neg_x <= r_f_neg_x;
            r_g_neg_z <= r_f_neg_z;
            r_g_ax <= r_f_ax;
            r_g_ay <= r_f_ay;
            r_g_az <= r_f_az;
            r_g_s  <= hne_pkg::SUM_W'(r_f_sx) + hne_pkg::SUM_W'(r_f_sy)
                    + hne_pkg::SUM_W'(r_f_sz);
        end
    end

    // square root: load, then one result bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_rt_vld[0] <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rt_v[0]    <= RW'(r_g_s) << hne_pkg::SQ_SHIFT;
            r_rt_r[0]    <= '0;
            r_rt_negx[0] <= r_g_neg_x;
            r_rt_negz[0] <= r_g_neg_z;
            r_rt_ax[0]   <= r_g_ax;
            r_rt_ay[0]   <= r_g_ay;
            r_rt_az[0]   <= r_g_az;
        end
    end

    for (genvar k = 0; k < NR; k++) begin : g_root
        localparam logic [RW-1:0] RBIT = RW'(1) << (2 * (NR - 1 - k));
        logic [RW-1:0] n_try;
        assign n_try = r_rt_r[k] + RBIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_rt_vld[k+1] <= r_rt_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_rt_v[k] >= n_try) begin
                    r_rt_v[k+1] <= r_rt_v[k] - n_try;
                    r_rt_r[k+1] <= (r_rt_r[k] >> 1) + RBIT;
                end else begin
                    r_rt_v[k+1] <= r_rt_v[k];
                    r_rt_r[k+1] <= r_rt_r[k] >> 1;
                end
                r_rt_negx[k+1] <= r_rt_negx[k];
                r_rt_negz[k+1] <= r_rt_negz[k];
                r_rt_ax[k+1]   <= r_rt_ax[k];
                r_rt_ay[k+1]   <= r_rt_ay[k];
                r_rt_az[k+1]   <= r_rt_az[k];
            end
        end
    end

    // divider load: numerator a * 2^24 + root / 2
    assign n_root = (r_rt_r[NR] == '0) ? RW'(1) : r_rt_r[NR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_vld[0] <= r_rt_vld[NR];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_r[0]      <= n_root;
            r_dv_negx[0]   <= r_rt_negx[NR];
            r_dv_negz[0]   <= r_rt_negz[NR];
            r_dv_rem[0][0] <= (RW'(r_rt_ax[NR]) << hne_pkg::FRAC_SHIFT) + (n_root >> 1);
            r_dv_rem[0][1] <= (RW'(r_rt_ay[NR]) << hne_pkg::FRAC_SHIFT) + (n_root >> 1);
            r_dv_rem[0][2] <= (RW'(r_rt_az[NR]) << hne_pkg::FRAC_SHIFT) + (n_root >> 1);
            r_dv_q[0][0]   <= '0;
            r_dv_q[0][1]   <= '0;
            r_dv_q[0][2]   <= '0;
        end
    end

    // restoring division: one quotient bit per stage, most significant first
    for (genvar j = 0; j < NQ; j++) begin : g_div
        localparam int SH = NQ - 1 - j;
        logic [RW-1:0] n_dsr;
        assign n_dsr = r_dv_r[j] << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_r[j+1]    <= r_dv_r[j];
                r_dv_negx[j+1] <= r_dv_negx[j];
                r_dv_negz[j+1] <= r_dv_negz[j];
                for (int l = 0; l < 3; l++) begin
                    if (r_dv_rem[j][l] >= n_dsr) begin
                        r_dv_rem[j+1][l] <= r_dv_rem[j][l] - n_dsr;
                        r_dv_q[j+1][l]   <= r_dv_q[j][l] | (NQ'(1) << SH);
                    end else begin
                        r_dv_rem[j+1][l] <= r_dv_rem[j][l];
                        r_dv_q[j+1][l]   <= r_dv_q[j][l];
                    end
                end
            end
        end
    end

    // clamp to one, apply signs
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_mag[l] = (r_dv_q[NQ][l] > hne_pkg::UNIT_Q) ? hne_pkg::UNIT_Q : r_dv_q[NQ][l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_dv_vld[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_nx <= r_dv_negx[NQ] ? (16'd0 - n_mag[0]) : n_mag[0];
            r_out_ny <= n_mag[1][hne_pkg::OUT_Y_W-1:0];
            r_out_nz <= r_dv_negz[NQ] ? (16'd0 - n_mag[2]) : n_mag[2];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_nz, r_out_ny, r_out_nx};

    `HNE_ASSERT_IMPL(a_ny_unit, i_clk, i_rst_n, r_out_vld, r_out_ny <= 15'd16384, "normal_y above one")
    `HNE_ASSERT_IMPL(a_nx_unit, i_clk, i_rst_n, r_out_vld, ($signed(r_out_nx) <= 16'sd16384) && ($signed(r_out_nx) >= -16'sd16384), "normal_x out of range")
    `HNE_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, w_adv && r_b_vld && (r_b_op == hne_pkg::OP_WRITE), !r_c_vld, "write item reached the result path")
    `HNE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_adv, $stable(r_rt_vld[0]) && $stable(r_c_vld) && $stable(r_dv_vld[0]), "pipeline moved during a stall")
endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the heightmap normal engine core.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] nz;
        logic [14:0] ny;
        logic [15:0] nx;
    } t_normal;

    class t_normal_scoreboard;
        int unsigned width, depth;
        logic signed [15:0] heights [16384];
        bit seen [16384];
        t_normal pending[$];
        int errors;

        function new();
            width = 128;
            depth = 128;
            errors = 0;
        endfunction

        function void configure(logic idx, logic [7:0] val);
            int unsigned v;
            v = (val < 3) ? 3 : ((val > 128) ? 128 : val);
            if (idx == hne_pkg::CFG_IDX_WIDTH) width = v;
            else depth = v;
        endfunction

        function int unsigned clamp_coord(int unsigned c, int unsigned size);
            if (c == 0) c = 1;
            if (c > size - 2) c = size - 2;
            return c;
        endfunction

        function longint unsigned root64(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint unsigned unit_scale(longint unsigned a, longint unsigned r);
            longint unsigned q;
            q = ((a << 24) + (r >> 1)) / r;
            return (q > 16384) ? 16384 : q;
        endfunction

        function void note_item(logic op, int unsigned x, int unsigned z,
                                logic signed [15:0] h);
            int unsigned xq, zq;
            longint signed dx, dz;
            longint unsigned ax, az, r;
            logic [15:0] mx, mz;
            t_normal n;
            if (op == hne_pkg::OP_WRITE) begin
                if (x < width && z < depth) begin
                    heights[x * depth + z] = h;
                    seen[x * depth + z] = 1'b1;
                end
                return;
            end
            xq = clamp_coord(x, width);
            zq = clamp_coord(z, depth);
            dx = longint'(heights[(xq - 1) * depth + zq]) - heights[(xq + 1) * depth + zq];
            dz = longint'(heights[xq * depth + zq + 1]) - heights[xq * depth + zq - 1];
            ax = (dx < 0) ? -dx : dx;
            az = (dz < 0) ? -dz : dz;
            r = root64((ax * ax + 512 * 512 + az * az) << 20);
            if (r == 0) r = 1;
            mx = 16'(unit_scale(ax, r));
            mz = 16'(unit_scale(az, r));
            n.nx = (dx < 0) ? -mx : mx;
            n.ny = 15'(unit_scale(512, r));
            n.nz = (dz < 0) ? -mz : mz;
            pending = {pending, n};
        endfunction

        function void check_result(t_normal got);
            t_normal want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected normal %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz) begin
                errors++;
                if (errors <= 10)
                    $display("normal mismatch: expected x=%h y=%h z=%h got x=%h y=%h z=%h",
                             want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [6:0] cell_x, [13:7] cell_z, [29:14] height_value
    logic        s_axis_tuser;   // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [15:0] normal_x, [30:16] normal_y, [46:31] normal_z

    t_normal_scoreboard sb = new();
    bit no_idle;
    int sent;
    longint cycles = 0;

    heightmap_normal_engine_core dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        bit hs;
        t_normal got;
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        m_axis_tready <= 1'b1;
        forever begin
            do begin
                @(negedge i_clk);
                hs = m_axis_tvalid && m_axis_tready;
                got = m_axis_tdata[46:0];
                @(posedge i_clk);
            end while (!hs);
            sb.check_result(got);
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic op, int unsigned x, int unsigned z, logic [15:0] h);
        int gap;
        bit hs;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, h, z[6:0], x[6:0]};
        do begin
            @(negedge i_clk);
            hs = s_axis_tready;
            @(posedge i_clk);
        end while (!hs);
        sb.note_item(op, x, z, h);
        sent++;
    endtask

    function automatic logic [15:0] pick_height();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    // fill any unwritten neighbor before querying
    task automatic send_query(int unsigned x, int unsigned z);
        int unsigned xq, zq, nxs[4], nzs[4];
        xq = sb.clamp_coord(x, sb.width);
        zq = sb.clamp_coord(z, sb.depth);
        nxs = '{xq - 1, xq + 1, xq, xq};
        nzs = '{zq, zq, zq - 1, zq + 1};
        for (int k = 0; k < 4; k++)
            if (!sb.seen[nxs[k] * sb.depth + nzs[k]])
                send_item(hne_pkg::OP_WRITE, nxs[k], nzs[k], pick_height());
        send_item(hne_pkg::OP_QUERY, x, z, 16'($urandom()));
    endtask

    task automatic drain_and_set(logic idx, logic [7:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.configure(idx, val);
    endtask

    initial begin
        logic [7:0] widths [9] = '{128, 3, 0, 5, 128, 3, 255, 17, 40};
        logic [7:0] depths [9] = '{128, 3, 1, 7, 3, 128, 200, 9, 64};
        int unsigned hx, hz, x, z;
        sent = 0;
        no_idle = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= hne_pkg::CFG_IDX_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= hne_pkg::OP_WRITE;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes around the low corner, clamped queries, flat patch
        send_item(hne_pkg::OP_WRITE, 0, 1, 16'h7FFF);
        send_item(hne_pkg::OP_WRITE, 2, 1, 16'h8000);
        send_item(hne_pkg::OP_WRITE, 1, 0, 16'h8000);
        send_item(hne_pkg::OP_WRITE, 1, 2, 16'h7FFF);
        send_query(0, 0);
        send_query(1, 1);
        send_item(hne_pkg::OP_WRITE, 0, 1, 16'h8000);
        send_item(hne_pkg::OP_WRITE, 2, 1, 16'h7FFF);
        send_query(1, 0);
        for (int k = 0; k < 4; k++)
            send_item(hne_pkg::OP_WRITE, 125 + k / 2 * 2, 125 + k % 2 * 2, 16'h0100);
        send_item(hne_pkg::OP_WRITE, 126, 125, 16'h0100);
        send_item(hne_pkg::OP_WRITE, 126, 127, 16'h0100);
        send_item(hne_pkg::OP_WRITE, 125, 126, 16'h0100);
        send_item(hne_pkg::OP_WRITE, 127, 126, 16'h0100);
        send_query(127, 127);
        send_query(126, 126);

        for (int p = 1; p < 9; p++) begin
            no_idle = (p % 3 == 0);
            drain_and_set(hne_pkg::CFG_IDX_WIDTH, widths[p]);
            drain_and_set(hne_pkg::CFG_IDX_DEPTH, depths[p]);
            if (p == 3) begin
                // write past the depth aliases an in-grid index and must be ignored
                send_query(2, 2);
                send_item(hne_pkg::OP_WRITE, 1, 7, 16'h4000);
                send_item(hne_pkg::OP_WRITE, 9, 0, 16'h4000);
                send_query(2, 2);
                send_query(100, 100);
            end
            hx = $urandom_range(0, sb.width - 1);
            hz = $urandom_range(0, sb.depth - 1);
            while (sent < 1850 * p / 8 + 40) begin
                x = $urandom_range(0, 127);
                z = $urandom_range(0, 127);
                if ($urandom_range(0, 3) != 0) begin
                    x = (hx + $urandom_range(0, 6) > 3) ? hx + $urandom_range(0, 6) - 3 : 0;
                    z = (hz + $urandom_range(0, 6) > 3) ? hz + $urandom_range(0, 6) - 3 : 0;
                    if (x > 127) x = 127;
                    if (z > 127) z = 127;
                end
                if ($urandom_range(0, 2) == 0) send_item(hne_pkg::OP_WRITE, x, z, pick_height());
                else send_query(x, z);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/hne_pkg.sv
rtl/heightmap_normal_engine_core.sv
verif/testbench.sv
